### src/bsc_pkg.sv
package bsc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_reg;

    localparam logic [7:0]            RST_THRESHOLD = 8'd240;
    localparam logic [CFG_DATA_W-1:0] RST_WIDTH     = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT    = 13'd480;

    // Accumulator widths
    localparam int SUM_W   = 36;
    localparam int COUNT_W = 25;
    localparam int POS_W   = 12;
    localparam int STEP_W  = $clog2(SUM_W);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Luma weights, 16-bit fixed point, sum to 65536
    localparam logic [16:0] LUMA_KR = 17'd19595;
    localparam logic [16:0] LUMA_KG = 17'd38470;
    localparam logic [16:0] LUMA_KB = 17'd7471;

    typedef struct packed {
        logic [7:0]         luma;
        logic               bright;
        logic               last;
        logic               none;
        logic [SUM_W-1:0]   num_x;
        logic [SUM_W-1:0]   num_y;
        logic [COUNT_W-1:0] den;
    } t_bsc_entry;

    typedef struct packed {
        logic [7:0]       luma;
        logic             bright;
        logic             frame_done;
        logic [POS_W-1:0] centroid_x;
        logic [POS_W-1:0] centroid_y;
        logic             none_bright;
    } t_bsc_result;

    // Weighted sum never exceeds 255 * 65536, so 24 bits hold it
    function automatic logic [7:0] bsc_luma(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [23:0] acc;
        acc = 24'(LUMA_KR) * 24'(r) + 24'(LUMA_KG) * 24'(g) + 24'(LUMA_KB) * 24'(b);
        return acc[23:16];
    endfunction

endpackage

### src/bsc_pix_if.sv
interface bsc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### src/bsc_res_if.sv
interface bsc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  luma;
    logic        bright;
    logic        frame_done;
    logic [11:0] centroid_x;
    logic [11:0] centroid_y;
    logic        none_bright;

    modport source (output valid, output luma, output bright, output frame_done,
                    output centroid_x, output centroid_y, output none_bright,
                    input ready);
    modport sink   (input valid, input luma, input bright, input frame_done,
                    input centroid_x, input centroid_y, input none_bright,
                    output ready);
endinterface

### src/bright_spot_centroid.sv
// Channel | Dir | Handshake            | Payload
// i_pix   | in  | valid/ready, sink    | red, green, blue (8 each)
// o_res   | out | valid/ready, source  | luma, bright, frame_done, centroid_x/y, none_bright
// i_cfg   | in  | i_cfg_we write strobe | i_cfg_idx (0 thr, 1 width, 2 height), i_cfg_data
//
// One pixel per cycle through the front while the queue has room; one result per pixel
// leaves a registered output. A frame's last pixel with bright pixels goes through the
// shared restoring divider (one quotient bit per cycle for both axes), then ST_EMIT.
// A 4-entry queue lets the front keep taking pixels during the division; it stalls when full.
// Synchronous active-low reset clears counters, sums, queue and output; config returns to
// threshold 240, 640 x 480.
module bright_spot_centroid #(
    parameter int MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  bsc_pkg::t_cfg_idx  i_cfg_idx,
    input  bsc_pkg::t_cfg_data i_cfg_data,
    bsc_pix_if.sink            i_pix,
    bsc_res_if.source          o_res
);
    import bsc_pkg::*;

    logic       w_push, w_pop, w_full, w_q_valid;
    t_bsc_entry w_push_entry, w_head_entry;

    bsc_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    bsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry)
    );

    bsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_entry   (w_head_entry),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

### src/bsc_front.sv
module bsc_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  bsc_pkg::t_cfg_idx    i_cfg_idx,
    input  bsc_pkg::t_cfg_data   i_cfg_data,
    bsc_pix_if.sink              i_pix,
    input  logic                 i_q_full,
    output logic                 o_push,
    output bsc_pkg::t_bsc_entry  o_entry
);
    import bsc_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [7:0]            r_thresh;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;

    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [SUM_W-1:0]   r_sum_x, n_sum_x;
    logic [SUM_W-1:0]   r_sum_y, n_sum_y;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [DIM_W-1:0] w_w_eff, w_h_eff;
    logic [7:0]       w_luma;
    logic             w_bright, w_row_end, w_last, w_accept;
    logic [POS_W-1:0] w_ctr_x, w_ctr_y;

    // Zero acts as one, oversize saturates
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= RST_THRESHOLD;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thresh <= i_cfg_data[7:0];
                CFG_WIDTH:     r_width  <= i_cfg_data;
                CFG_HEIGHT:    r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the pixel and find its place in the frame
    always_comb begin
        w_accept  = i_pix.valid && !i_q_full;
        w_w_eff   = eff_dim(r_width);
        w_h_eff   = eff_dim(r_height);
        w_luma    = bsc_luma(i_pix.red, i_pix.green, i_pix.blue);
        w_bright  = w_luma > r_thresh;
        w_row_end = DIM_W'(r_col) >= (w_w_eff - DIM_W'(1));
        w_last    = w_row_end && (DIM_W'(r_row) >= (w_h_eff - DIM_W'(1)));
        w_ctr_x   = POS_W'(w_w_eff >> 1);
        w_ctr_y   = POS_W'(w_h_eff >> 1);

        n_sum_x = w_bright ? r_sum_x + SUM_W'(r_col) : r_sum_x;
        n_sum_y = w_bright ? r_sum_y + SUM_W'(r_row) : r_sum_y;
        n_count = w_bright ? r_count + COUNT_W'(1) : r_count;

        if (w_last) begin
            n_col = '0;
            n_row = '0;
        end else if (w_row_end) begin
            n_col = '0;
            n_row = r_row + CNT_W'(1);
        end else begin
            n_col = r_col + CNT_W'(1);
            n_row = r_row;
        end
    end

    // Advance counters and sums, clear them after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (w_last) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_count <= '0;
            end else begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_count <= n_count;
            end
        end
    end

    // Build the queue entry; centre goes straight into the numerator fields
    always_comb begin
        o_entry.luma   = w_luma;
        o_entry.bright = w_bright;
        o_entry.last   = w_last;
        o_entry.none   = w_last && (n_count == '0);
        o_entry.den    = n_count;
        if (!w_last) begin
            o_entry.num_x = '0;
            o_entry.num_y = '0;
        end else if (n_count == '0) begin
            o_entry.num_x = SUM_W'(w_ctr_x);
            o_entry.num_y = SUM_W'(w_ctr_y);
        end else begin
            o_entry.num_x = n_sum_x;
            o_entry.num_y = n_sum_y;
        end
    end

    assign o_push      = w_accept;
    assign i_pix.ready = !i_q_full;

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_col == '0 && r_row == '0 && r_count == '0))
        else $error("frame state not cleared after last pixel");

endmodule

### src/bsc_fifo.sv
module bsc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bsc_pkg::t_bsc_entry  i_entry,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output bsc_pkg::t_bsc_entry  o_entry
);
    import bsc_pkg::*;

    t_bsc_entry        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];

    a_fill_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + (QPTR_W+1)'(1)))
        else $error("queue level did not rise on push");

endmodule

### src/bsc_back.sv
module bsc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  bsc_pkg::t_bsc_entry  i_entry,
    output logic                 o_pop,
    bsc_res_if.source            o_res
);
    import bsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic               r_out_valid;
    t_bsc_result        r_out;
    logic [7:0]         r_luma;
    logic               r_bright;
    logic [COUNT_W-1:0] r_den;
    logic [COUNT_W-1:0] r_rem_x, r_rem_y, n_rem_x, n_rem_y;
    logic [SUM_W-1:0]   r_quo_x, r_quo_y, n_quo_x, n_quo_y;
    logic [STEP_W-1:0]  r_step;

    logic [COUNT_W:0] w_sh_x, w_sh_y, w_sub_x, w_sub_y;
    logic             w_ge_x, w_ge_y, w_slot, w_pop, w_load;

    // One restoring division step for both axes
    always_comb begin
        w_sh_x  = {r_rem_x, r_quo_x[SUM_W-1]};
        w_sh_y  = {r_rem_y, r_quo_y[SUM_W-1]};
        w_ge_x  = w_sh_x >= {1'b0, r_den};
        w_ge_y  = w_sh_y >= {1'b0, r_den};
        w_sub_x = w_sh_x - {1'b0, r_den};
        w_sub_y = w_sh_y - {1'b0, r_den};
        n_rem_x = w_ge_x ? w_sub_x[COUNT_W-1:0] : w_sh_x[COUNT_W-1:0];
        n_rem_y = w_ge_y ? w_sub_y[COUNT_W-1:0] : w_sh_y[COUNT_W-1:0];
        n_quo_x = {r_quo_x[SUM_W-2:0], w_ge_x};
        n_quo_y = {r_quo_y[SUM_W-2:0], w_ge_y};
    end

    assign w_slot = !r_out_valid || o_res.ready;
    assign w_pop  = (r_state == ST_IDLE) && i_q_valid && w_slot;

    // Load the output register from a direct request or a finished division
    assign w_load = (w_pop && !(i_entry.last && !i_entry.none)) ||
                    ((r_state == ST_EMIT) && w_slot);

    // Pop requests, run the divider on frame ends, fill the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_pop) begin
                        if (i_entry.last && !i_entry.none) begin
                            r_luma   <= i_entry.luma;
                            r_bright <= i_entry.bright;
                            r_den    <= i_entry.den;
                            r_rem_x  <= '0;
                            r_rem_y  <= '0;
                            r_quo_x  <= i_entry.num_x;
                            r_quo_y  <= i_entry.num_y;
                            r_step   <= '0;
                            r_state  <= ST_DIV;
                        end else begin
                            r_out.luma        <= i_entry.luma;
                            r_out.bright      <= i_entry.bright;
                            r_out.frame_done  <= i_entry.last;
                            r_out.centroid_x  <= i_entry.num_x[POS_W-1:0];
                            r_out.centroid_y  <= i_entry.num_y[POS_W-1:0];
                            r_out.none_bright <= i_entry.none;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem_x <= n_rem_x;
                    r_rem_y <= n_rem_y;
                    r_quo_x <= n_quo_x;
                    r_quo_y <= n_quo_y;
                    r_step  <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_slot) begin
                        r_out.luma        <= r_luma;
                        r_out.bright      <= r_bright;
                        r_out.frame_done  <= 1'b1;
                        r_out.centroid_x  <= r_quo_x[POS_W-1:0];
                        r_out.centroid_y  <= r_quo_y[POS_W-1:0];
                        r_out.none_bright <= 1'b0;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_pop             = w_pop;
    assign o_res.valid       = r_out_valid;
    assign o_res.luma        = r_out.luma;
    assign o_res.bright      = r_out.bright;
    assign o_res.frame_done  = r_out.frame_done;
    assign o_res.centroid_x  = r_out.centroid_x;
    assign o_res.centroid_y  = r_out.centroid_y;
    assign o_res.none_bright = r_out.none_bright;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_den != '0))
        else $error("divider running with zero count");

    a_pop_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (r_state == ST_DIV || r_out_valid))
        else $error("popped request went nowhere");

    a_emit_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_slot) |=> (r_out_valid && r_out.frame_done))
        else $error("divided centroid not presented as frame end");

endmodule
